>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while in reset.
`define PFAD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge.
`define PFAD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`PFAD_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> rtl/pfad_pkg.sv
`timescale 1ns / 1ps
package pfad_pkg;

	// Frame pool: fixed by the result field widths
	localparam int FRAME_COUNT = 8;
	localparam int FRAME_W     = 3;
	localparam int COUNT_W     = 4;

	// Request field widths
	localparam int FUNC_W   = 2;
	localparam int DIR_W    = 2;
	localparam int SLOT_W   = 10;
	localparam int AMOUNT_W = 11;

	// Stored entry: present bit over frame number
	localparam int ENTRY_W = FRAME_W + 1;

	localparam int SLOTS_PER_DIR       = 1 << SLOT_W;
	localparam int DIRECTORY_COUNT_DEF = 4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CHECK = 2'd0,
		FUNC_ALLOC = 2'd1,
		FUNC_FREE  = 2'd2
	} func_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic read;
		logic exec;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic out_full;
	} ctrl_sts_t;

endpackage

>>> rtl/page_frame_allocator_with_directory_core.sv
`timescale 1ns / 1ps
// First-fit allocator for 8 physical frames with a page-directory store
// of DIRECTORY_COUNT x 1024 entries. tuser selects the request: check whether
// an amount fits in the free count, allocate the lowest free frame and map it
// at the given slot, or free the mapping at a slot. Each request gives one
// result: ok, frame number and the free count afterwards. A request holds the
// block through its capture, directory memory read and update steps. The
// update registers its result, and the next request is taken in the cycle
// after the update. The update waits only while the previous result is still
// untaken. After reset a clearing pass zeroes all DIRECTORY_COUNT x 1024
// directory memory entries (4096 by default) one entry a cycle, with
// s_tready low.
module page_frame_allocator_with_directory_core #(
	parameter int DIRECTORY_COUNT = pfad_pkg::DIRECTORY_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// dir_select[1:0], virtual_page[11:2], amount[22:12], zero[23]
	input  logic [23:0]                  s_tdata,
	// func[1:0]
	input  logic [pfad_pkg::FUNC_W-1:0]  s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// ok[0], frame_index[3:1], free_count[7:4]
	output logic [7:0]                   m_tdata
);
	import pfad_pkg::*;

	ctrl_cmd_t          cmd;
	ctrl_sts_t          sts;
	logic               res_ok;
	logic [FRAME_W-1:0] res_frame;
	logic [COUNT_W-1:0] res_count;

	pfad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfad_datapath #(
		.DIRECTORY_COUNT (DIRECTORY_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_func   (s_tuser),
		.req_dir    (s_tdata[1:0]),
		.req_slot   (s_tdata[11:2]),
		.req_amount (s_tdata[22:12]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.res_ok     (res_ok),
		.res_frame  (res_frame),
		.res_count  (res_count)
	);

	assign m_tdata = {res_count, res_frame, res_ok};

endmodule

>>> rtl/pfad_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfad_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  pfad_pkg::ctrl_sts_t   sts,
	output pfad_pkg::ctrl_cmd_t   cmd
);
	import pfad_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;

	// Sequencer: clear sweep, then accept / read / update per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_READ;
						ready_q <= 1'b0;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					// wait for the result slot to drain
					if (!sts.out_full) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign s_tready = ready_q;

	// Datapath commands
	always_comb begin
		cmd.capture = s_tvalid && ready_q;
		cmd.clear   = (state_q == ST_CLEAR);
		cmd.read    = (state_q == ST_READ);
		cmd.exec    = (state_q == ST_EXEC) && !sts.out_full;
	end

	`PFAD_ASSERT(a_ready_only_idle, clk, arst_n, ready_q |-> (state_q == ST_IDLE), "ready outside idle")
	`PFAD_ASSERT(a_accept_reads, clk, arst_n, cmd.capture |=> (state_q == ST_READ), "no read after accept")
	`PFAD_ASSERT(a_read_then_exec, clk, arst_n, (state_q == ST_READ) |=> (state_q == ST_EXEC), "read not followed by update")

endmodule

>>> rtl/pfad_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfad_datapath #(
	parameter int DIRECTORY_COUNT = pfad_pkg::DIRECTORY_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfad_pkg::ctrl_cmd_t            cmd,
	output pfad_pkg::ctrl_sts_t            sts,
	input  logic [pfad_pkg::FUNC_W-1:0]    req_func,
	input  logic [pfad_pkg::DIR_W-1:0]     req_dir,
	input  logic [pfad_pkg::SLOT_W-1:0]    req_slot,
	input  logic [pfad_pkg::AMOUNT_W-1:0]  req_amount,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic                           res_ok,
	output logic [pfad_pkg::FRAME_W-1:0]   res_frame,
	output logic [pfad_pkg::COUNT_W-1:0]   res_count
);
	import pfad_pkg::*;

	localparam int MEM_DEPTH = DIRECTORY_COUNT * SLOTS_PER_DIR;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	// Captured request
	func_t               func_q;
	logic [DIR_W-1:0]    dir_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [AMOUNT_W-1:0] amount_q;

	// Allocator state
	logic [FRAME_COUNT-1:0] used_q;
	logic [COUNT_W-1:0]     free_q;

	// Directory store
	logic [ENTRY_W-1:0] mem_q [MEM_DEPTH];
	logic [ENTRY_W-1:0] rd_q;
	logic [MEM_AW-1:0]  clr_q;

	// Result register
	logic               out_valid_q;
	logic               out_ok_q;
	logic [FRAME_W-1:0] out_frame_q;
	logic [COUNT_W-1:0] out_count_q;

	logic [MEM_AW-1:0]      addr;
	logic                   dir_ok;
	logic                   first_found;
	logic [FRAME_W-1:0]     first_idx;
	logic [FRAME_W-1:0]     rd_frame;
	logic [FRAME_COUNT-1:0] used_d;
	logic [COUNT_W-1:0]     free_d;
	logic                   ent_we;
	logic [ENTRY_W-1:0]     ent_d;
	logic                   ok_d;
	logic [FRAME_W-1:0]     frame_d;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= func_t'(req_func);
			dir_q    <= req_dir;
			slot_q   <= req_slot;
			amount_q <= req_amount;
		end
	end

	// Slot address; fits whenever the directory is in range
	assign addr     = MEM_AW'({dir_q, slot_q});
	assign dir_ok   = {30'd0, dir_q} < 32'(DIRECTORY_COUNT);
	assign rd_frame = rd_q[FRAME_W-1:0];

	// Lowest free frame
	always_comb begin
		first_found = 1'b0;
		first_idx   = '0;
		for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				first_found = 1'b1;
				first_idx   = FRAME_W'(i);
			end
		end
	end

	// Request update
	always_comb begin
		used_d  = used_q;
		free_d  = free_q;
		ent_we  = 1'b0;
		ent_d   = '0;
		ok_d    = 1'b0;
		frame_d = '0;
		case (func_q)
			FUNC_CHECK: begin
				ok_d = (amount_q <= AMOUNT_W'(free_q));
			end
			FUNC_ALLOC: begin
				if (dir_ok && first_found) begin
					used_d[first_idx] = 1'b1;
					if (free_q != '0)
						free_d = free_q - COUNT_W'(1);
					ent_we  = 1'b1;
					ent_d   = {1'b1, first_idx};
					ok_d    = 1'b1;
					frame_d = first_idx;
				end
			end
			FUNC_FREE: begin
				// present entry: release its frame and clear the slot
				if (dir_ok && rd_q[FRAME_W]) begin
					if (used_q[rd_frame]) begin
						used_d[rd_frame] = 1'b0;
						if (free_q < COUNT_W'(FRAME_COUNT))
							free_d = free_q + COUNT_W'(1);
					end
					ent_we  = 1'b1;
					ent_d   = '0;
					ok_d    = 1'b1;
					frame_d = rd_frame;
				end
			end
			default: ;
		endcase
	end

	// Bitmap and free count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			free_q <= COUNT_W'(FRAME_COUNT);
		end else if (cmd.exec) begin
			used_q <= used_d;
			free_q <= free_d;
		end
	end

	// Clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clear)
			clr_q <= clr_q + MEM_AW'(1);
	end

	// Directory store: one write port, one registered read
	always_ff @(posedge clk) begin
		if (cmd.clear)
			mem_q[clr_q] <= '0;
		else if (cmd.exec && ent_we)
			mem_q[addr] <= ent_d;
		if (cmd.read)
			rd_q <= mem_q[addr];
	end

	// Result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.exec)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_ok_q    <= ok_d;
			out_frame_q <= frame_d;
			out_count_q <= free_d;
		end
	end

	assign sts.clear_last = (clr_q == MEM_AW'(MEM_DEPTH - 1));
	assign sts.out_full   = out_valid_q && !m_tready;

	assign m_tvalid  = out_valid_q;
	assign res_ok    = out_ok_q;
	assign res_frame = out_frame_q;
	assign res_count = out_count_q;

	`PFAD_ASSERT(a_count_matches_bitmap, clk, arst_n, free_q == COUNT_W'(FRAME_COUNT - $countones(used_q)), "free count out of step with bitmap")
	`PFAD_ASSERT(a_exec_gives_result, clk, arst_n, cmd.exec |=> out_valid_q, "update without result")
	`PFAD_ASSERT_NEVER(a_no_exec_during_clear, clk, arst_n, cmd.exec && cmd.clear, "update during clear sweep")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import pfad_pkg::*;

	localparam int DIR_COUNT       = DIRECTORY_COUNT_DEF;
	localparam int STORE_DEPTH     = DIR_COUNT * SLOTS_PER_DIR;
	// Covers the directory clearing pass after reset with plenty to spare
	localparam int STALL_LIMIT     = 20000;
	localparam int RANDOM_REQUESTS = 1080;
	localparam int CALM_REQUESTS   = 150;
	localparam int REPORT_LIMIT    = 10;
	localparam int SETTLE_CYCLES   = 8;
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [DIR_W-1:0]    dir;
		logic [SLOT_W-1:0]   vpage;
		logic [AMOUNT_W-1:0] amount;
	} alloc_req_t;

	typedef struct packed {
		logic               ok;
		logic [FRAME_W-1:0] frame;
		logic [COUNT_W-1:0] count;
	} alloc_res_t;

	// One directed request; typed rows carry their own answer
	typedef struct packed {
		alloc_req_t req;
		logic       typed;
		alloc_res_t res;
	} table_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [23:0]       s_tdata;
	logic [FUNC_W-1:0] s_tuser;
	logic              m_tvalid;
	logic              m_tready = 1'b1;
	logic [7:0]        m_tdata;

	page_frame_allocator_with_directory_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow of the allocator state
	logic [FRAME_COUNT-1:0] frame_taken = '0;
	logic [COUNT_W-1:0]     frames_left = COUNT_W'(FRAME_COUNT);
	logic [ENTRY_W-1:0]     dir_store [STORE_DEPTH] = '{default: '0};

	alloc_res_t   awaited_results [$];
	table_row_t   directed_rows [$];
	logic         row_typed;
	alloc_res_t   row_result;
	bit           calm;
	int           error_count = 0;
	int           quiet_cycles = 0;
	int unsigned  stall_left = 0;

	// Apply one request to the shadow state and return its answer
	function automatic alloc_res_t predict_allocator(input alloc_req_t req);
		alloc_res_t res;
		int slot;
		logic [ENTRY_W-1:0] entry;
		logic [FRAME_W-1:0] f;
		res = '0;
		slot = int'(req.dir) * SLOTS_PER_DIR + int'(req.vpage);
		if (req.func == FUNC_CHECK) begin
			res.ok = (int'(req.amount) <= int'(frames_left));
		end else if (req.func == FUNC_ALLOC && int'(req.dir) < DIR_COUNT) begin
			// first fit: lowest free frame wins
			for (int i = 0; i < FRAME_COUNT; i++) begin
				if (!res.ok && !frame_taken[i]) begin
					frame_taken[i] = 1'b1;
					if (frames_left != 0)
						frames_left = frames_left - 1'b1;
					dir_store[slot] = {1'b1, FRAME_W'(i)};
					res.ok = 1'b1;
					res.frame = FRAME_W'(i);
				end
			end
		end else if (req.func == FUNC_FREE && int'(req.dir) < DIR_COUNT) begin
			entry = dir_store[slot];
			if (entry[ENTRY_W-1]) begin
				f = entry[FRAME_W-1:0];
				// count only moves if the frame really was in use
				if (frame_taken[f]) begin
					frame_taken[f] = 1'b0;
					if (frames_left < FRAME_COUNT)
						frames_left = frames_left + 1'b1;
				end
				dir_store[slot] = '0;
				res.ok = 1'b1;
				res.frame = f;
			end
		end
		res.count = frames_left;
		return res;
	endfunction

	function automatic void add_row(input logic [FUNC_W-1:0] func, input int dir,
			input int vpage, input int amount, input logic typed,
			input logic ok, input int frame, input int count);
		table_row_t row;
		row.req.func   = func;
		row.req.dir    = DIR_W'(dir);
		row.req.vpage  = SLOT_W'(vpage);
		row.req.amount = AMOUNT_W'(amount);
		row.typed      = typed;
		row.res.ok     = ok;
		row.res.frame  = FRAME_W'(frame);
		row.res.count  = COUNT_W'(count);
		directed_rows.push_back(row);
	endfunction

	// Present one request at the falling edge and hold it until taken
	task automatic send_request(input alloc_req_t req, input logic typed,
			input alloc_res_t res);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tdata    = {1'b0, req.amount, req.vpage, req.dir};
		s_tuser    = req.func;
		row_typed  = typed;
		row_result = res;
		s_tvalid   = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Result side back-pressure in short bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_tready = 1'b0;
			stall_left = stall_left - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			m_tready = 1'b0;
			stall_left = $urandom_range(0, 5);
		end else begin
			m_tready = 1'b1;
		end
	end

	// Predict on each accepted request, check each taken result, watch for hangs
	always @(posedge clk) begin
		alloc_req_t req;
		alloc_res_t want;
		alloc_res_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				req.func   = s_tuser;
				req.dir    = s_tdata[1:0];
				req.vpage  = s_tdata[11:2];
				req.amount = s_tdata[22:12];
				want = predict_allocator(req);
				if (row_typed)
					want = row_result;
				awaited_results.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.ok    = m_tdata[0];
				got.frame = m_tdata[3:1];
				got.count = m_tdata[7:4];
				if (awaited_results.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: result with no request outstanding: ok %0d frame %0d free %0d",
							$time, got.ok, got.frame, got.count);
				end else begin
					want = awaited_results.pop_front();
					if (got.ok !== want.ok || got.frame !== want.frame ||
							got.count !== want.count) begin
						error_count++;
						if (error_count <= REPORT_LIMIT)
							$display("%0t: mismatch: ok %0d/%0d frame %0d/%0d free %0d/%0d (exp/got)",
								$time, want.ok, got.ok, want.frame, got.frame,
								want.count, got.count);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		alloc_req_t req;
		alloc_res_t none;
		int unsigned pick;
		none         = '0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = FUNC_CHECK;
		row_typed    = 1'b0;
		row_result   = '0;
		calm         = 1'b0;

		// func, dir, vpage, amount, typed, ok, frame, free count
		add_row(FUNC_CHECK, 0, 0, 0, 1, 1, 0, 8);
		add_row(FUNC_CHECK, 0, 0, 8, 1, 1, 0, 8);
		add_row(FUNC_CHECK, 0, 0, 9, 1, 0, 0, 8);
		add_row(FUNC_CHECK, 3, 1023, 2047, 1, 0, 0, 8);
		// free of a slot never mapped
		add_row(FUNC_FREE, 0, 0, 0, 1, 0, 0, 8);
		add_row(FUNC_SPARE, 2, 512, 3, 1, 0, 0, 8);
		add_row(FUNC_ALLOC, 0, 0, 2047, 1, 1, 0, 7);
		add_row(FUNC_ALLOC, 3, 1023, 0, 1, 1, 1, 6);
		// remap over a live entry: frame 0 is orphaned and stays used
		add_row(FUNC_ALLOC, 0, 0, 0, 1, 1, 2, 5);
		add_row(FUNC_FREE, 0, 0, 0, 1, 1, 2, 6);
		add_row(FUNC_FREE, 0, 0, 0, 1, 0, 0, 6);
		for (int v = 5; v <= 10; v++)
			add_row(FUNC_ALLOC, 1, v, 0, 0, 0, 0, 0);
		// pool exhausted
		add_row(FUNC_ALLOC, 2, 7, 0, 1, 0, 0, 0);
		add_row(FUNC_CHECK, 0, 0, 0, 1, 1, 0, 0);
		add_row(FUNC_CHECK, 0, 0, 1, 1, 0, 0, 0);
		add_row(FUNC_FREE, 3, 1023, 0, 0, 0, 0, 0);
		add_row(FUNC_FREE, 1, 5, 0, 0, 0, 0, 0);
		add_row(FUNC_ALLOC, 2, 7, 0, 0, 0, 0, 0);
		add_row(FUNC_CHECK, 1, 300, 1024, 0, 0, 0, 0);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

		// Random traffic over a few hot slots so frees often hit live mappings
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS - CALM_REQUESTS)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 20)
				req.func = FUNC_CHECK;
			else if (pick < 58)
				req.func = FUNC_ALLOC;
			else if (pick < 95)
				req.func = FUNC_FREE;
			else
				req.func = FUNC_SPARE;
			req.dir = DIR_W'($urandom_range(0, 3));
			pick = $urandom_range(0, 9);
			if (pick == 0)
				req.vpage = SLOT_W'($urandom);
			else if (pick < 5)
				req.vpage = SLOT_W'($urandom_range(0, 2));
			else
				req.vpage = SLOT_W'(SLOTS_PER_DIR - 1 - $urandom_range(0, 2));
			pick = $urandom_range(0, 9);
			if (pick < 7)
				req.amount = AMOUNT_W'($urandom_range(0, FRAME_COUNT + 1));
			else if (pick < 9)
				req.amount = AMOUNT_W'($urandom_range(0, SLOTS_PER_DIR));
			else
				req.amount = AMOUNT_W'($urandom);
			send_request(req, 1'b0, none);
		end
		s_tvalid = 1'b0;

		// Drain, then let the block settle to show any stray result
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
